>>> rtl/stm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stm_pkg;

  // screens that keep a frame maximum
  localparam int NUM_SCREENS = 8;
  localparam int SCR_W = (NUM_SCREENS > 1) ? $clog2(NUM_SCREENS) : 1;
  localparam logic [SCR_W-1:0] LAST_SCR = SCR_W'(NUM_SCREENS - 1);

  // reported screen fields are 3 bits wide
  localparam int SCR_OUT_W = 3;

  localparam logic [15:0] CEIL16 = 16'hFFFF;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // stream widths
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 208;

  // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [31:0] SANE_MAX_RST     = 32'd1000000;
  localparam logic [31:0] FRAME_BUDGET_RST = 32'd33333;
  localparam logic [31:0] PASS_BUDGET_RST  = 32'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SANE_MAX     = 2'd0,
    CFG_FRAME_BUDGET = 2'd1,
    CFG_PASS_BUDGET  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FN_FRAME      = 2'd0,
    FN_PASS       = 2'd1,
    FN_SET_SCREEN = 2'd2,
    FN_CLEAR      = 2'd3
  } func_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_wr_t;

  // classified request handed from front to back
  typedef struct packed {
    func_t            func;
    logic [31:0]      span;
    logic             accepted;
    logic             over;
    logic             ceil;
    logic             sel_ok;
    logic [SCR_W-1:0] sel_idx;
  } item_t;

  typedef struct packed {
    logic [15:0]          screen_max_us;
    logic                 max_saturated;
    logic [31:0]          frame_worst_us;
    logic [SCR_OUT_W-1:0] frame_worst_screen;
    logic [31:0]          pass_worst_us;
    logic [SCR_OUT_W-1:0] pass_worst_screen;
    logic [15:0]          frame_overruns;
    logic [15:0]          pass_overruns;
    logic [31:0]          frame_count;
    logic [31:0]          pass_count;
    logic [15:0]          discard_count;
    logic [SCR_OUT_W-1:0] billed_screen;
  } res_t;

  function automatic logic [SCR_OUT_W-1:0] scr_field(input logic [SCR_W-1:0] s);
    logic [SCR_W+SCR_OUT_W-1:0] wide;
    wide = {{SCR_OUT_W{1'b0}}, s};
    return wide[SCR_OUT_W-1:0];
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == CEIL16) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/stm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stm_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire stm_pkg::cfg_wr_t                cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [stm_pkg::IN_DATA_W-1:0]   in_data,
  input  wire logic [stm_pkg::IN_USER_W-1:0]   in_user,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output stm_pkg::item_t                       push_item
);

  logic [31:0] sane_max;
  logic [31:0] frame_budget;
  logic [31:0] pass_budget;

  logic           f_valid;
  stm_pkg::item_t f_item;
  stm_pkg::item_t f_item_next;

  logic [31:0]         begin_stamp;
  logic [31:0]         end_stamp;
  logic [7:0]          screen_sel;
  stm_pkg::func_t      func;
  logic [31:0]         span;
  logic [31:0]         budget;
  logic                accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      sane_max     <= stm_pkg::SANE_MAX_RST;
      frame_budget <= stm_pkg::FRAME_BUDGET_RST;
      pass_budget  <= stm_pkg::PASS_BUDGET_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        stm_pkg::CFG_SANE_MAX:     sane_max     <= cfg.data;
        stm_pkg::CFG_FRAME_BUDGET: frame_budget <= cfg.data;
        stm_pkg::CFG_PASS_BUDGET:  pass_budget  <= cfg.data;
        default: ;
      endcase
    end
  end

  assign begin_stamp = in_data[31:0];
  assign end_stamp   = in_data[63:32];
  assign screen_sel  = in_data[71:64];
  assign func        = stm_pkg::func_t'(in_user);

  assign in_ready = !f_valid || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    span   = end_stamp - begin_stamp;
    budget = (func == stm_pkg::FN_FRAME) ? frame_budget : pass_budget;
    f_item_next.func     = func;
    f_item_next.span     = span;
    f_item_next.accepted = (span <= sane_max);
    f_item_next.over     = (span > budget);
    f_item_next.ceil     = (span[31:16] != 16'd0) || (span[15:0] == stm_pkg::CEIL16);
    f_item_next.sel_ok   = ({1'b0, screen_sel} < 9'(stm_pkg::NUM_SCREENS));
    f_item_next.sel_idx  = screen_sel[stm_pkg::SCR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= f_item_next;
    end
  end

  assign push_valid = f_valid;
  assign push_item  = f_item;

endmodule

`default_nettype wire

>>> rtl/stm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module stm_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire stm_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output stm_pkg::item_t      pop_item
);

  stm_pkg::item_t entries [stm_pkg::QDEPTH];

  logic [stm_pkg::QPTR_W-1:0] wr_ptr;
  logic [stm_pkg::QPTR_W-1:0] rd_ptr;
  logic [stm_pkg::QCNT_W-1:0] count;
  logic                       push;
  logic                       pop;

  assign push_ready = (count != stm_pkg::QCNT_W'(stm_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  function automatic logic [stm_pkg::QPTR_W-1:0] ptr_inc(input logic [stm_pkg::QPTR_W-1:0] p);
    return (p == stm_pkg::QPTR_W'(stm_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= stm_pkg::QCNT_W'(stm_pkg::QDEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");
`endif

endmodule

`default_nettype wire

>>> rtl/stm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stm_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire stm_pkg::item_t pop_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output stm_pkg::res_t       out_res
);

  logic [15:0] tbl      [stm_pkg::NUM_SCREENS];
  logic [15:0] tbl_next [stm_pkg::NUM_SCREENS];

  logic                      sat;
  logic [31:0]               frame_worst;
  logic [stm_pkg::SCR_W-1:0] frame_worst_scr;
  logic [31:0]               pass_worst;
  logic [stm_pkg::SCR_W-1:0] pass_worst_scr;
  logic [15:0]               frame_over_cnt;
  logic [15:0]               pass_over_cnt;
  logic [31:0]               frame_cnt;
  logic [31:0]               pass_cnt;
  logic [15:0]               discard_cnt;
  logic [stm_pkg::SCR_W-1:0] cur_scr;

  logic                      sat_next;
  logic [31:0]               frame_worst_next;
  logic [stm_pkg::SCR_W-1:0] frame_worst_scr_next;
  logic [31:0]               pass_worst_next;
  logic [stm_pkg::SCR_W-1:0] pass_worst_scr_next;
  logic [15:0]               frame_over_cnt_next;
  logic [15:0]               pass_over_cnt_next;
  logic [31:0]               frame_cnt_next;
  logic [31:0]               pass_cnt_next;
  logic [15:0]               discard_cnt_next;
  logic [stm_pkg::SCR_W-1:0] cur_scr_next;

  logic          pop;
  stm_pkg::res_t res_next;

  assign pop_ready = !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    sat_next             = sat;
    frame_worst_next     = frame_worst;
    frame_worst_scr_next = frame_worst_scr;
    pass_worst_next      = pass_worst;
    pass_worst_scr_next  = pass_worst_scr;
    frame_over_cnt_next  = frame_over_cnt;
    pass_over_cnt_next   = pass_over_cnt;
    frame_cnt_next       = frame_cnt;
    pass_cnt_next        = pass_cnt;
    discard_cnt_next     = discard_cnt;
    cur_scr_next         = cur_scr;

    if (pop) begin
      unique case (pop_item.func)
        stm_pkg::FN_FRAME: begin
          if (pop_item.accepted) begin
            frame_cnt_next = frame_cnt + 32'd1;
            if (pop_item.over) frame_over_cnt_next = stm_pkg::sat_inc16(frame_over_cnt);
            if (pop_item.ceil) sat_next = 1'b1;
            if (pop_item.span > frame_worst) begin
              frame_worst_next     = pop_item.span;
              frame_worst_scr_next = cur_scr;
            end
          end else begin
            discard_cnt_next = stm_pkg::sat_inc16(discard_cnt);
          end
        end
        stm_pkg::FN_PASS: begin
          if (pop_item.accepted) begin
            pass_cnt_next = pass_cnt + 32'd1;
            if (pop_item.over) pass_over_cnt_next = stm_pkg::sat_inc16(pass_over_cnt);
            if (pop_item.span > pass_worst) begin
              pass_worst_next     = pop_item.span;
              pass_worst_scr_next = cur_scr;
            end
          end else begin
            discard_cnt_next = stm_pkg::sat_inc16(discard_cnt);
          end
        end
        stm_pkg::FN_SET_SCREEN: begin
          cur_scr_next = pop_item.sel_ok ? pop_item.sel_idx : stm_pkg::LAST_SCR;
        end
        stm_pkg::FN_CLEAR: begin
          sat_next             = 1'b0;
          frame_worst_next     = '0;
          frame_worst_scr_next = '0;
          pass_worst_next      = '0;
          pass_worst_scr_next  = '0;
          frame_over_cnt_next  = '0;
          pass_over_cnt_next   = '0;
          frame_cnt_next       = '0;
          pass_cnt_next        = '0;
          discard_cnt_next     = '0;
        end
        default: ;
      endcase
    end
  end

  // each screen entry has its own compare against the span
  always_comb begin
    for (int i = 0; i < stm_pkg::NUM_SCREENS; i++) begin
      tbl_next[i] = tbl[i];
      if (pop) begin
        if (pop_item.func == stm_pkg::FN_CLEAR) begin
          tbl_next[i] = '0;
        end else if (pop_item.func == stm_pkg::FN_FRAME && pop_item.accepted &&
                     cur_scr == stm_pkg::SCR_W'(i)) begin
          if (pop_item.ceil) begin
            tbl_next[i] = stm_pkg::CEIL16;
          end else if (pop_item.span[15:0] > tbl[i]) begin
            tbl_next[i] = pop_item.span[15:0];
          end
        end
      end
    end
  end

  always_comb begin
    res_next.screen_max_us      = pop_item.sel_ok ? tbl_next[pop_item.sel_idx] : 16'd0;
    res_next.max_saturated      = sat_next;
    res_next.frame_worst_us     = frame_worst_next;
    res_next.frame_worst_screen = stm_pkg::scr_field(frame_worst_scr_next);
    res_next.pass_worst_us      = pass_worst_next;
    res_next.pass_worst_screen  = stm_pkg::scr_field(pass_worst_scr_next);
    res_next.frame_overruns     = frame_over_cnt_next;
    res_next.pass_overruns      = pass_over_cnt_next;
    res_next.frame_count        = frame_cnt_next;
    res_next.pass_count         = pass_cnt_next;
    res_next.discard_count      = discard_cnt_next;
    res_next.billed_screen      = stm_pkg::scr_field(cur_scr_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < stm_pkg::NUM_SCREENS; i++) tbl[i] <= '0;
      sat             <= 1'b0;
      frame_worst     <= '0;
      frame_worst_scr <= '0;
      pass_worst      <= '0;
      pass_worst_scr  <= '0;
      frame_over_cnt  <= '0;
      pass_over_cnt   <= '0;
      frame_cnt       <= '0;
      pass_cnt        <= '0;
      discard_cnt     <= '0;
      cur_scr         <= '0;
      out_valid       <= 1'b0;
    end else begin
      for (int i = 0; i < stm_pkg::NUM_SCREENS; i++) tbl[i] <= tbl_next[i];
      sat             <= sat_next;
      frame_worst     <= frame_worst_next;
      frame_worst_scr <= frame_worst_scr_next;
      pass_worst      <= pass_worst_next;
      pass_worst_scr  <= pass_worst_scr_next;
      frame_over_cnt  <= frame_over_cnt_next;
      pass_over_cnt   <= pass_over_cnt_next;
      frame_cnt       <= frame_cnt_next;
      pass_cnt        <= pass_cnt_next;
      discard_cnt     <= discard_cnt_next;
      cur_scr         <= cur_scr_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_idle_holds_count: assert property (@(posedge clk) disable iff (rst)
    !pop |=> $stable(frame_cnt) && $stable(pass_cnt) && $stable(discard_cnt))
    else $error("statistics moved without a request");
  a_screen_range: assert property (@(posedge clk) disable iff (rst)
    cur_scr <= stm_pkg::LAST_SCR)
    else $error("billed screen out of range");
  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    sat && !(pop && pop_item.func == stm_pkg::FN_CLEAR) |=> sat)
    else $error("saturation flag dropped without a clear");
`endif

endmodule

`default_nettype wire

>>> rtl/span_timing_monitor.sv
// path: a request passes the front register, a queue entry and the result register
// throughput: one request per cycle unless m_tready stalls; while a finished result waits
//   on m_tready, front stage and two-entry queue take up to three more requests
// reset: synchronous active-high rst clears all statistics, the billed screen and the queue
//   and loads the default sanity limit and budgets; the first request may follow at once
`timescale 1ns / 1ps
`default_nettype none

module span_timing_monitor (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [31:0] begin_stamp, [63:32] end_stamp, [71:64] screen_sel
  input  wire logic [stm_pkg::IN_DATA_W-1:0]     s_tdata,
  // [1:0] func
  input  wire logic [stm_pkg::IN_USER_W-1:0]     s_tuser,
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [15:0] screen_max_us, [16] max_saturated, [48:17] frame_worst_us,
  // [51:49] frame_worst_screen, [83:52] pass_worst_us, [86:84] pass_worst_screen,
  // [102:87] frame_overruns, [118:103] pass_overruns, [150:119] frame_count,
  // [182:151] pass_count, [198:183] discard_count, [201:199] billed_screen,
  // [207:202] zero
  output logic [stm_pkg::OUT_DATA_W-1:0]         m_tdata,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [stm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                       cfg_data
);

  stm_pkg::cfg_wr_t cfg;
  logic             q_push_valid;
  logic             q_push_ready;
  stm_pkg::item_t   q_push_item;
  logic             q_pop_valid;
  logic             q_pop_ready;
  stm_pkg::item_t   q_pop_item;
  stm_pkg::res_t    res;

  // registers are plain flops, a write lands whenever rst is low
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // front: span subtract, sanity, budget and ceiling compares, screen range check
  stm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .in_user    (s_tuser),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item)
  );

  // short queue so front and back stall on their own
  stm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  // back: statistics update and result register
  stm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_item  (q_pop_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // last listed field in the lowest bits
  assign m_tdata = {6'd0,
                    res.billed_screen,
                    res.discard_count,
                    res.pass_count,
                    res.frame_count,
                    res.pass_overruns,
                    res.frame_overruns,
                    res.pass_worst_screen,
                    res.pass_worst_us,
                    res.frame_worst_screen,
                    res.frame_worst_us,
                    res.max_saturated,
                    res.screen_max_us};

endmodule

`default_nettype wire

>>> tb/sv/span_timing_checker.sv
`timescale 1ns / 1ps

module span_timing_checker
  import stm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [OUT_DATA_W-1:0] m_tdata,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]           cfg_data,
  output int                         fails,
  output int                         outstanding
);

  // result word, lowest field last
  typedef struct packed {
    logic [5:0]  pad;
    logic [2:0]  billed_screen;
    logic [15:0] discard_count;
    logic [31:0] pass_count;
    logic [31:0] frame_count;
    logic [15:0] pass_overruns;
    logic [15:0] frame_overruns;
    logic [2:0]  pass_worst_screen;
    logic [31:0] pass_worst_us;
    logic [2:0]  frame_worst_screen;
    logic [31:0] frame_worst_us;
    logic        max_saturated;
    logic [15:0] screen_max_us;
  } snapshot_t;

  logic [31:0]      span_limit, frame_budget, pass_budget;
  logic [15:0]      max_tab [NUM_SCREENS];
  logic             ceil_hit;
  logic [31:0]      frame_peak, pass_peak;
  logic [SCR_W-1:0] frame_peak_scr, pass_peak_scr, bill_scr;
  logic [15:0]      frame_over, pass_over, drop_total;
  logic [31:0]      frame_total, pass_total;
  snapshot_t        expected_snaps [$];
  int               mismatches = 0;

  assign fails = mismatches;
  initial outstanding = 0;

  function automatic void wipe_stats();
    foreach (max_tab[i]) max_tab[i] = '0;
    ceil_hit = 1'b0;
    frame_peak = '0;
    pass_peak = '0;
    frame_peak_scr = '0;
    pass_peak_scr = '0;
    frame_over = '0;
    pass_over = '0;
    drop_total = '0;
    frame_total = '0;
    pass_total = '0;
  endfunction

  // update the statistics for one request and return the snapshot it yields
  function automatic snapshot_t apply_request(input func_t fn, input logic [31:0] t0,
                                              input logic [31:0] t1, input logic [7:0] sel);
    logic [31:0] span;
    snapshot_t   snap;
    span = t1 - t0;
    if ((fn == FN_FRAME || fn == FN_PASS) && span > span_limit) begin
      if (drop_total != CEIL16) drop_total++;
    end else if (fn == FN_FRAME) begin
      frame_total++;
      if (span > frame_budget && frame_over != CEIL16) frame_over++;
      if (span >= 32'(CEIL16)) begin
        max_tab[bill_scr] = CEIL16;
        ceil_hit = 1'b1;
      end else if (span[15:0] > max_tab[bill_scr]) begin
        max_tab[bill_scr] = span[15:0];
      end
      if (span > frame_peak) begin
        frame_peak = span;
        frame_peak_scr = bill_scr;
      end
    end else if (fn == FN_PASS) begin
      pass_total++;
      if (span > pass_budget && pass_over != CEIL16) pass_over++;
      if (span > pass_peak) begin
        pass_peak = span;
        pass_peak_scr = bill_scr;
      end
    end else if (fn == FN_SET_SCREEN) begin
      bill_scr = (sel < NUM_SCREENS) ? SCR_W'(sel) : LAST_SCR;
    end else begin
      wipe_stats();
    end
    snap = '0;
    snap.screen_max_us      = (sel < NUM_SCREENS) ? max_tab[SCR_W'(sel)] : 16'd0;
    snap.max_saturated      = ceil_hit;
    snap.frame_worst_us     = frame_peak;
    snap.frame_worst_screen = 3'(frame_peak_scr);
    snap.pass_worst_us      = pass_peak;
    snap.pass_worst_screen  = 3'(pass_peak_scr);
    snap.frame_overruns     = frame_over;
    snap.pass_overruns      = pass_over;
    snap.frame_count        = frame_total;
    snap.pass_count         = pass_total;
    snap.discard_count      = drop_total;
    snap.billed_screen      = 3'(bill_scr);
    return snap;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_snapshot(input snapshot_t want, input snapshot_t got);
    check_field("screen_max_us", 32'(want.screen_max_us), 32'(got.screen_max_us));
    check_field("max_saturated", 32'(want.max_saturated), 32'(got.max_saturated));
    check_field("frame_worst_us", want.frame_worst_us, got.frame_worst_us);
    check_field("frame_worst_screen", 32'(want.frame_worst_screen),
                32'(got.frame_worst_screen));
    check_field("pass_worst_us", want.pass_worst_us, got.pass_worst_us);
    check_field("pass_worst_screen", 32'(want.pass_worst_screen), 32'(got.pass_worst_screen));
    check_field("frame_overruns", 32'(want.frame_overruns), 32'(got.frame_overruns));
    check_field("pass_overruns", 32'(want.pass_overruns), 32'(got.pass_overruns));
    check_field("frame_count", want.frame_count, got.frame_count);
    check_field("pass_count", want.pass_count, got.pass_count);
    check_field("discard_count", 32'(want.discard_count), 32'(got.discard_count));
    check_field("billed_screen", 32'(want.billed_screen), 32'(got.billed_screen));
    check_field("pad", 32'(want.pad), 32'(got.pad));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      span_limit = SANE_MAX_RST;
      frame_budget = FRAME_BUDGET_RST;
      pass_budget = PASS_BUDGET_RST;
      wipe_stats();
      bill_scr = '0;
      expected_snaps.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SANE_MAX:     span_limit = cfg_data;
          CFG_FRAME_BUDGET: frame_budget = cfg_data;
          CFG_PASS_BUDGET:  pass_budget = cfg_data;
          default: ;
        endcase
      end
      // a result never leaves in its request's cycle, so pop before push
      if (m_tvalid && m_tready) begin
        if (expected_snaps.size() == 0) begin
          $error("result with no request outstanding: %0h", m_tdata);
          mismatches++;
        end else begin
          compare_snapshot(expected_snaps.pop_front(), snapshot_t'(m_tdata));
        end
      end
      if (s_tvalid && s_tready)
        expected_snaps.push_back(apply_request(func_t'(s_tuser), s_tdata[31:0],
                                               s_tdata[63:32], s_tdata[71:64]));
    end
    outstanding <= expected_snaps.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import stm_pkg::*;

  logic                  clk;
  logic                  rst = 1'b1;
  // request side, driven at the rising edge
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  // [31:0] begin_stamp, [63:32] end_stamp, [71:64] screen_sel
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // [1:0] func
  logic [IN_USER_W-1:0]  s_tuser = '0;
  // result side
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  // [15:0] screen_max_us ... [201:199] billed_screen, [207:202] zero
  wire [OUT_DATA_W-1:0]  m_tdata;
  // register writes
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [31:0]           cfg_data = '0;

  int fails;
  int outstanding;

  // idle odds out of a hundred for each side, changed per phase
  int send_pct = 23;
  int recv_pct = 87;

  // our copy of the registers, used to aim spans at the limits
  logic [31:0] span_limit = SANE_MAX_RST;
  logic [31:0] frame_budget = FRAME_BUDGET_RST;
  logic [31:0] pass_budget = PASS_BUDGET_RST;

  span_timing_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  span_timing_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fails       (fails),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result-side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_pct);
  end

  // one request; valid stays up across back-to-back requests so it is
  // only lowered inside the idle loop
  task automatic push_req(input func_t fn, input logic [31:0] t0, input logic [31:0] t1,
                          input logic [7:0] sel);
    while ($urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sel, t1, t0};
    s_tuser  <= fn;
    do @(posedge clk); while (!s_tready);
  endtask

  // wait until every result has come back; outstanding is registered, and
  // the first edge here covers its lag
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // all three registers in one burst, valid dropped once at the end
  task automatic write_regs(input logic [31:0] lim, input logic [31:0] fb,
                            input logic [31:0] pb);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SANE_MAX;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_FRAME_BUDGET;
    cfg_data  <= fb;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_PASS_BUDGET;
    cfg_data  <= pb;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    span_limit = lim;
    frame_budget = fb;
    pass_budget = pb;
  endtask

  // spans clustered at zero, the budgets, the sanity limit and the 16-bit ceiling
  function automatic logic [31:0] pick_span();
    case ($urandom_range(9))
      0:       return 32'($urandom_range(100));
      1, 2:    return 32'($urandom_range(70000));
      3:       return 32'hFFFD + 32'($urandom_range(4));
      4:       return span_limit - 32'd2 + 32'($urandom_range(4));
      5:       return frame_budget - 32'd2 + 32'($urandom_range(4));
      6:       return pass_budget - 32'd2 + 32'($urandom_range(4));
      7:       return $urandom();
      8:       return 32'($urandom_range(1000000));
      default: return 32'($urandom_range(20000));
    endcase
  endfunction

  // mostly spans, some screen changes, the odd clear
  task automatic rand_req();
    logic [31:0] t0;
    logic [7:0]  sel;
    int          r;
    func_t       fn;
    t0 = $urandom();
    r = $urandom_range(99);
    sel = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(9));
    if (r < 45)      fn = FN_FRAME;
    else if (r < 82) fn = FN_PASS;
    else if (r < 97) fn = FN_SET_SCREEN;
    else             fn = FN_CLEAR;
    push_req(fn, t0, t0 + pick_span(), sel);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // phase one: sender idles lightly, receiver stalls hard, reset registers
    // zero span, then a span that wraps through zero
    push_req(FN_FRAME, 32'd0, 32'd0, 8'd0);
    push_req(FN_FRAME, 32'hFFFF_FFF0, 32'h0000_0010, 8'd0);
    push_req(FN_SET_SCREEN, $urandom(), $urandom(), 8'd3);
    // frame budget boundary: equal does not overrun, one more does
    push_req(FN_FRAME, 32'd100, 32'd100 + FRAME_BUDGET_RST, 8'd3);
    push_req(FN_FRAME, 32'd0, FRAME_BUDGET_RST + 32'd1, 8'd3);
    push_req(FN_FRAME, 32'd5, 32'd5 + 32'hFFFE, 8'd3);
    // set beyond the last screen clamps; span of exactly the ceiling saturates
    push_req(FN_SET_SCREEN, $urandom(), $urandom(), 8'd255);
    push_req(FN_FRAME, 32'd7, 32'd7 + 32'hFFFF, 8'd7);
    // span equal to the sanity limit is kept, one above is dropped
    push_req(FN_FRAME, 32'd0, SANE_MAX_RST, 8'd8);
    push_req(FN_FRAME, 32'd0, SANE_MAX_RST + 32'd1, 8'd200);
    push_req(FN_PASS, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'd255);
    // pass budget boundary
    push_req(FN_PASS, 32'd1, 32'd1 + PASS_BUDGET_RST, 8'd1);
    push_req(FN_PASS, 32'd1, 32'd2 + PASS_BUDGET_RST, 8'd7);
    push_req(FN_SET_SCREEN, $urandom(), $urandom(), 8'd8);
    push_req(FN_SET_SCREEN, $urandom(), $urandom(), 8'd0);
    push_req(FN_PASS, 32'd0, SANE_MAX_RST, 8'd0);
    push_req(FN_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd7);
    // clear keeps the billed screen
    push_req(FN_CLEAR, $urandom(), $urandom(), 8'd7);
    push_req(FN_FRAME, 32'd0, 32'd50, 8'd0);
    push_req(FN_SET_SCREEN, $urandom(), $urandom(), 8'd5);
    push_req(FN_PASS, 32'd0, 32'd20, 8'd5);
    push_req(FN_CLEAR, $urandom(), $urandom(), 8'd5);
    repeat (150) rand_req();
    settle();

    // phase two: roles swapped, random registers, then all at zero
    send_pct = 87;
    recv_pct = 23;
    write_regs(32'($urandom_range(2000000)), 32'($urandom_range(70000)),
               32'($urandom_range(20000)));
    repeat (120) rand_req();
    settle();
    write_regs(32'd0, 32'd0, 32'd0);
    repeat (25) rand_req();
    settle();

    // phase three: no idling on either side; registers at the top of their range, then random
    send_pct = 0;
    recv_pct = 0;
    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (50) rand_req();
    settle();
    write_regs($urandom(), $urandom(), $urandom());
    repeat (50) rand_req();
    settle();

    // tight sanity limit with both budgets at zero
    write_regs(32'd100, 32'd0, 32'd0);
    repeat (10) rand_req();
    settle();

    if (fails == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/stm_pkg.sv
rtl/stm_front.sv
rtl/stm_fifo.sv
rtl/stm_back.sv
rtl/span_timing_monitor.sv
tb/sv/span_timing_checker.sv
tb/sv/tb_top.sv
